/* sv/ps2_byte_receiver_defines.svh */
// Assertion macros used by the PS/2 byte receiver core.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef PS2_BYTE_RECEIVER_DEFINES_SVH
`define PS2_BYTE_RECEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PS2BR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2br assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PS2BR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2br assertion failed");

`endif

/* sv/ps2br_pkg.sv */
// Package for the PS/2 byte receiver: payload structs, config and status codes.
// Has no dependencies; every module imports it.
package ps2br_pkg;

  localparam int unsigned TICK_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [COUNT_W-1:0] FIRST_DATA_BIT = 4'd1;
  localparam logic [COUNT_W-1:0] LAST_DATA_BIT  = 4'd8;
  localparam logic [COUNT_W-1:0] FRAME_BITS     = 4'd11;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd100000;
  localparam logic [TICK_W-1:0] TICK_MAX      = '1;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_TIMEOUT_TICKS = 1'b0;
  localparam cfg_index_t CFG_PORT_ENABLED  = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ARM    = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  typedef struct packed {
    logic kind;
    logic clk_level;
    logic data_level;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] timeout_ticks;
    logic              port_enabled;
  } cfg_t;

  typedef struct packed {
    logic      fire;
    out_item_t item;
  } result_t;

endpackage

/* sv/ps2br_cfg.sv */
// Configuration registers of the PS/2 byte receiver.
// Depends on ps2br_pkg for the register index codes and the cfg_t struct.
module ps2br_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  ps2br_pkg::cfg_index_t               wr_index,
  input  logic [ps2br_pkg::CFG_DATA_W-1:0]    wr_data,
  output ps2br_pkg::cfg_t                     cfg
);
  import ps2br_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = wr_data[TICK_W-1:0];
        CFG_PORT_ENABLED:  cfg_nxt.port_enabled  = wr_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
      cfg_r.port_enabled  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/ps2br_core.sv */
// Receive state and combinational frame update of the PS/2 byte receiver.
// Depends on ps2br_pkg and on ps2_byte_receiver_defines.svh for assertions.
`include "ps2_byte_receiver_defines.svh"

module ps2br_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ps2br_pkg::in_item_t item,
  input  ps2br_pkg::cfg_t     cfg,
  output ps2br_pkg::result_t  res
);
  import ps2br_pkg::*;

  logic               armed_r,   armed_nxt;
  logic [COUNT_W-1:0] count_r,   count_nxt;
  logic [BYTE_W-1:0]  shift_r,   shift_nxt;
  logic               last_clk_r, last_clk_nxt;
  logic [TICK_W-1:0]  ticks_r,   ticks_nxt;
  logic               fall;

  assign fall = !item.clk_level && last_clk_r;

  always_comb begin
    armed_nxt    = armed_r;
    count_nxt    = count_r;
    shift_nxt    = shift_r;
    last_clk_nxt = last_clk_r;
    ticks_nxt    = ticks_r;
    res          = '0;
    if (step) begin
      if (item.kind == KIND_ARM) begin
        armed_nxt    = 1'b1;
        count_nxt    = '0;
        last_clk_nxt = 1'b1;
        ticks_nxt    = '0;
      end else if (armed_r && cfg.port_enabled) begin
        if (ticks_r != TICK_MAX) begin
          ticks_nxt = ticks_r + 1'b1;
        end
        last_clk_nxt = item.clk_level;
        if (fall) begin
          if (count_r >= FIRST_DATA_BIT && count_r <= LAST_DATA_BIT) begin
            shift_nxt = {item.data_level, shift_r[BYTE_W-1:1]};
          end
          count_nxt = count_r + 1'b1;
        end
        if (count_nxt >= FRAME_BITS) begin
          res.fire = 1'b1;
          res.item.status = STATUS_OK;
        end else if (ticks_nxt >= cfg.timeout_ticks) begin
          res.fire = 1'b1;
          res.item.status = STATUS_TIMEOUT;
        end
        if (res.fire) begin
          res.item.rx_byte = shift_nxt;
          shift_nxt = '0;
          count_nxt = '0;
          armed_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      count_r    <= '0;
      shift_r    <= '0;
      last_clk_r <= 1'b1;
      ticks_r    <= '0;
    end else begin
      armed_r    <= armed_nxt;
      count_r    <= count_nxt;
      shift_r    <= shift_nxt;
      last_clk_r <= last_clk_nxt;
      ticks_r    <= ticks_nxt;
    end
  end

  // A result only ever comes from a sample transfer processed this cycle.
  `PS2BR_ASSERT_SAME(a_fire_from_sample, res.fire, step && item.kind == KIND_SAMPLE)
  `PS2BR_ASSERT_SAME(a_count_in_frame, 1'b1, count_r < FRAME_BITS)
  `PS2BR_ASSERT_SAME(a_idle_is_clear, !armed_r, count_r == '0 && shift_r == '0)
  `PS2BR_ASSERT_NEXT(a_fire_disarms, res.fire, !armed_r)

endmodule

/* sv/ps2_byte_receiver.sv */
// A polled PS/2 device-to-host byte receiver. Each transfer is either an arm
// command or one sample of the clock and data pins; a frame is decoded on
// falling clock edges and the byte, or the partial byte on timeout, comes out
// as one result. One item is taken every cycle while the output is not stalled;
// a sample passes through the input register, then the combinational state
// update in ps2br_core, whose result is held in the output register.
// Depends on ps2br_pkg, ps2br_cfg and ps2br_core.
module ps2_byte_receiver (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ps2br_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ps2br_pkg::out_item_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  ps2br_pkg::cfg_index_t            cfg_index,
  input  logic [ps2br_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ps2br_pkg::*;

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      step;
  cfg_t      cfg;
  result_t   res;

  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  ps2br_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  ps2br_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (res.fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (res.fire) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
